/* design/ba_pkg.sv */
`default_nettype none
package ba_pkg;

  localparam int MAX_HEAP_ORDER_DEF = 16;
  localparam int MIN_ORDER_DEF      = 4;

  // result codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_BLOCK = 2'd1;
  localparam logic [1:0] ST_TOO_BIG  = 2'd2;
  localparam logic [1:0] ST_IGNORED  = 2'd3;

  // function codes
  localparam logic FN_ALLOC = 1'b0;
  localparam logic FN_FREE  = 1'b1;

  // register indexes
  localparam logic [1:0] REG_HEAP_BASE    = 2'd0;
  localparam logic [1:0] REG_HEAP_ORDER   = 2'd1;
  localparam logic [1:0] REG_HEADER_BYTES = 2'd2;

  localparam logic [4:0] HEAP_ORDER_RST   = 5'd16;
  localparam logic [7:0] HEADER_BYTES_RST = 8'd24;

  typedef struct packed {
    logic        func;
    logic [16:0] request_bytes;
    logic [31:0] free_address;
  } ba_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] address;
    logic [16:0] used_bytes;
  } ba_rsp_t;

  typedef struct packed {
    logic [1:0]  index;
    logic [31:0] value;
  } ba_cfg_t;

endpackage
`default_nettype wire

/* design/ba_chan_if.sv */
`default_nettype none
interface ba_chan_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

/* design/buddy_allocator.sv */
`default_nettype none
// channel  dir  payload                                   handshake
// req      in   func, request_bytes, free_address         valid/ready
// rsp      out  status, address, used_bytes               valid/ready
// cfg      in   index, value (heap_base/order/header)     valid/ready, ready always high
//
// one item at a time; alloc steps one order at a time while sizing and searching, then
// splits each larger block down; free merges the block with each free buddy in turn,
// and a null free address is answered as ignored
// reset and every register write start a clearing pass over all
// 2^(MAX_HEAP_ORDER-MIN_ORDER) order memory entries, during which no item is taken
// a result waits in the output register; the next item is taken once the block is idle
module buddy_allocator #(
  parameter int MAX_HEAP_ORDER = ba_pkg::MAX_HEAP_ORDER_DEF,
  parameter int MIN_ORDER      = ba_pkg::MIN_ORDER_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  ba_chan_if.sink    req,
  ba_chan_if.sink    cfg,
  ba_chan_if.source  rsp
);
  import ba_pkg::*;

  localparam int GW     = MAX_HEAP_ORDER - MIN_ORDER;
  localparam int GRAN   = 1 << GW;
  localparam int PW     = GW + 1;
  localparam int LEVELS = MAX_HEAP_ORDER - MIN_ORDER + 1;
  localparam int LW     = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int OW     = 5;
  localparam int UW     = (MAX_HEAP_ORDER + 1 > 17) ? MAX_HEAP_ORDER + 1 : 17;
  localparam int NW     = (MAX_HEAP_ORDER + 1 > 18) ? MAX_HEAP_ORDER + 1 : 18;
  localparam logic [PW-1:0] NIL  = PW'(GRAN);
  localparam logic [OW-1:0] KMIN = OW'(MIN_ORDER);
  localparam logic [OW-1:0] KMAX = OW'(MAX_HEAP_ORDER);

  localparam logic [4:0] S_CLR  = 5'd0;
  localparam logic [4:0] S_IDLE = 5'd1;
  localparam logic [4:0] S_AK   = 5'd2;
  localparam logic [4:0] S_AS   = 5'd3;
  localparam logic [4:0] S_ASPL = 5'd4;
  localparam logic [4:0] S_ASP1 = 5'd5;
  localparam logic [4:0] S_ASP2 = 5'd6;
  localparam logic [4:0] S_ASP3 = 5'd7;
  localparam logic [4:0] S_AF0  = 5'd8;
  localparam logic [4:0] S_AF1  = 5'd9;
  localparam logic [4:0] S_AADR = 5'd10;
  localparam logic [4:0] S_F1   = 5'd11;
  localparam logic [4:0] S_F2   = 5'd12;
  localparam logic [4:0] S_M0   = 5'd13;
  localparam logic [4:0] S_M1   = 5'd14;
  localparam logic [4:0] S_M2   = 5'd15;
  localparam logic [4:0] S_RM0  = 5'd16;
  localparam logic [4:0] S_RM1  = 5'd17;
  localparam logic [4:0] S_PU0  = 5'd18;
  localparam logic [4:0] S_PU1  = 5'd19;
  localparam logic [4:0] S_FIN  = 5'd20;

  logic [4:0]    st, ret;
  logic [31:0]   heap_base, bh, off;
  logic [4:0]    heap_order;
  logic [7:0]    header_bytes;
  logic [GW-1:0] cnt, g, b, op_g;
  logic [OW-1:0] k, s, op_k;
  logic [PW-1:0] h;
  logic [NW-1:0] need;
  logic [UW-1:0] used;
  logic [1:0]    status;
  logic [31:0]   address;
  logic          out_valid;
  ba_rsp_t       out_data;
  logic [PW-1:0] head [LEVELS];

  // link and order memories
  logic [PW-1:0] nxt_mem [GRAN];
  logic [PW-1:0] prv_mem [GRAN];
  logic [OW:0]   gm_mem  [GRAN];
  logic [PW-1:0] nxt_rd, prv_rd, nxt_wd, prv_wd;
  logic [GW-1:0] nxt_wa, prv_wa, gm_wa, gm_ra;
  logic          nxt_we, prv_we, gm_we;
  logic [OW:0]   gm_rd, gm_wd;

  always_ff @(posedge clk) begin
    if (nxt_we) nxt_mem[nxt_wa] <= nxt_wd;
    nxt_rd <= nxt_mem[op_g];
  end

  always_ff @(posedge clk) begin
    if (prv_we) prv_mem[prv_wa] <= prv_wd;
    prv_rd <= prv_mem[op_g];
  end

  always_ff @(posedge clk) begin
    if (gm_we) gm_mem[gm_wa] <= gm_wd;
    gm_rd <= gm_mem[gm_ra];
  end

  logic [OW-1:0] top;
  logic [LW-1:0] op_lvl, s_lvl;
  logic [GW-1:0] off_g, buddy_bit, half_bit, g_min;
  logic          off_bad, gm_free;
  logic [OW-1:0] gm_ord;
  logic [UW-1:0] one_k, one_gk;
  logic          cfg_hit;

  assign top = (heap_order < KMIN) ? KMIN : ((heap_order > KMAX) ? KMAX : heap_order);
  assign op_lvl    = LW'(op_k - KMIN);
  assign s_lvl     = LW'(s - KMIN);
  assign off_g     = off[MIN_ORDER +: GW];
  assign off_bad   = ((off >> top) != 32'd0) || (off[MIN_ORDER-1:0] != '0);
  assign buddy_bit = GW'(1) << (k - KMIN);
  assign half_bit  = GW'(1) << (s - KMIN - OW'(1));
  assign g_min     = (b < g) ? b : g;
  assign gm_free   = gm_rd[OW];
  assign gm_ord    = gm_rd[OW-1:0];
  assign one_k     = UW'(1) << k;
  assign one_gk    = UW'(1) << gm_ord;
  assign cfg_hit   = cfg.valid && (cfg.data.index == REG_HEAP_BASE ||
                     cfg.data.index == REG_HEAP_ORDER || cfg.data.index == REG_HEADER_BYTES);

  always_comb begin
    nxt_we = 1'b0; nxt_wa = op_g; nxt_wd = NIL;
    prv_we = 1'b0; prv_wa = op_g; prv_wd = NIL;
    gm_we  = 1'b0; gm_wa  = g;    gm_wd  = {1'b1, KMIN};
    gm_ra  = off_g;
    unique case (st)
      S_CLR: begin
        gm_we = 1'b1;
        gm_wa = cnt;
        gm_wd = (cnt == '0) ? {1'b1, top} : {1'b1, KMIN};
        if (cnt == '0) begin
          nxt_we = 1'b1; nxt_wa = '0;
          prv_we = 1'b1; prv_wa = '0;
        end
      end
      S_RM1: begin
        if (!prv_rd[GW]) begin
          nxt_we = 1'b1; nxt_wa = prv_rd[GW-1:0]; nxt_wd = nxt_rd;
        end
        if (!nxt_rd[GW]) begin
          prv_we = 1'b1; prv_wa = nxt_rd[GW-1:0]; prv_wd = prv_rd;
        end
      end
      S_PU0: begin
        prv_we = 1'b1;
        nxt_we = 1'b1; nxt_wd = head[op_lvl];
        gm_we  = 1'b1; gm_wa = op_g; gm_wd = {1'b1, op_k};
      end
      S_PU1: begin
        if (!h[GW]) begin
          prv_we = 1'b1; prv_wa = h[GW-1:0]; prv_wd = {1'b0, op_g};
        end
      end
      S_AF1: begin
        gm_we = 1'b1; gm_wd = {1'b0, k};
      end
      S_F2: begin
        if (!(gm_free || gm_ord < KMIN || gm_ord > top)) begin
          gm_we = 1'b1; gm_wd = {1'b1, gm_ord};
        end
      end
      S_M0: gm_ra = g ^ buddy_bit;
      S_M2: begin
        gm_we = 1'b1; gm_wa = g_min; gm_wd = {1'b1, k + OW'(1)};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st           <= S_CLR;
      cnt          <= '0;
      heap_base    <= '0;
      heap_order   <= HEAP_ORDER_RST;
      header_bytes <= HEADER_BYTES_RST;
      out_valid    <= 1'b0;
    end else begin
      if (out_valid && rsp.ready && (cfg_hit || st != S_FIN)) out_valid <= 1'b0;
      if (cfg_hit) begin
        // a register write restarts the heap
        st  <= S_CLR;
        cnt <= '0;
      end else begin
        unique case (st)
          S_CLR: begin
            bh  <= heap_base + 32'(header_bytes);
            cnt <= cnt + GW'(1);
            if (cnt == '0) begin
              used <= '0;
              for (int i = 0; i < LEVELS; i++)
                head[i] <= (i == int'(top) - MIN_ORDER) ? PW'(0) : NIL;
            end
            if (cnt == GW'(GRAN - 1)) st <= S_IDLE;
          end
          S_IDLE: begin
            if (req.valid) begin
              address <= '0;
              if (req.data.func == FN_ALLOC) begin
                need <= NW'(req.data.request_bytes) + NW'(header_bytes);
                k    <= KMIN;
                st   <= S_AK;
              end else if (req.data.free_address == 32'd0) begin
                status <= ST_IGNORED;
                st     <= S_FIN;
              end else begin
                off <= req.data.free_address - bh;
                st  <= S_F1;
              end
            end
          end
          S_AK: begin
            if (k > top) begin
              status <= ST_TOO_BIG;
              st     <= S_FIN;
            end else if ((NW'(1) << k) < need) begin
              k <= k + OW'(1);
            end else begin
              s  <= k;
              st <= S_AS;
            end
          end
          S_AS: begin
            if (s > top) begin
              status <= ST_NO_BLOCK;
              st     <= S_FIN;
            end else if (head[s_lvl][GW]) begin
              s <= s + OW'(1);
            end else if (s > k) begin
              st <= S_ASPL;
            end else begin
              st <= S_AF0;
            end
          end
          S_ASPL: begin
            g    <= head[s_lvl][GW-1:0];
            op_g <= head[s_lvl][GW-1:0];
            op_k <= s;
            ret  <= S_ASP1;
            st   <= S_RM0;
          end
          S_ASP1: begin
            op_g <= g + half_bit;
            op_k <= s - OW'(1);
            ret  <= S_ASP2;
            st   <= S_PU0;
          end
          S_ASP2: begin
            op_g <= g;
            op_k <= s - OW'(1);
            ret  <= S_ASP3;
            st   <= S_PU0;
          end
          S_ASP3: begin
            s  <= s - OW'(1);
            st <= S_AS;
          end
          S_AF0: begin
            g    <= head[s_lvl][GW-1:0];
            op_g <= head[s_lvl][GW-1:0];
            op_k <= k;
            ret  <= S_AF1;
            st   <= S_RM0;
          end
          S_AF1: begin
            used   <= used + one_k;
            status <= ST_OK;
            st     <= S_AADR;
          end
          S_AADR: begin
            address <= bh + (32'(g) << MIN_ORDER);
            st      <= S_FIN;
          end
          S_F1: begin
            g <= off_g;
            if (off_bad) begin
              status <= ST_IGNORED;
              st     <= S_FIN;
            end else begin
              st <= S_F2;
            end
          end
          S_F2: begin
            if (gm_free || gm_ord < KMIN || gm_ord > top) begin
              status <= ST_IGNORED;
              st     <= S_FIN;
            end else begin
              k    <= gm_ord;
              used <= (used >= one_gk) ? used - one_gk : '0;
              st   <= S_M0;
            end
          end
          S_M0: begin
            if (k >= top) begin
              op_g <= g;
              op_k <= k;
              ret  <= S_FIN;
              status <= ST_OK;
              st   <= S_PU0;
            end else begin
              b  <= g ^ buddy_bit;
              st <= S_M1;
            end
          end
          S_M1: begin
            op_k <= k;
            if (!gm_free || gm_ord != k) begin
              op_g   <= g;
              ret    <= S_FIN;
              status <= ST_OK;
              st     <= S_PU0;
            end else begin
              op_g <= b;
              ret  <= S_M2;
              st   <= S_RM0;
            end
          end
          S_M2: begin
            g  <= g_min;
            k  <= k + OW'(1);
            st <= S_M0;
          end
          S_RM0: st <= S_RM1;
          S_RM1: begin
            if (prv_rd[GW]) head[op_lvl] <= nxt_rd;
            st <= ret;
          end
          S_PU0: begin
            h            <= head[op_lvl];
            head[op_lvl] <= {1'b0, op_g};
            st           <= S_PU1;
          end
          S_PU1: st <= ret;
          S_FIN: begin
            if (!out_valid || rsp.ready) begin
              out_data.status     <= status;
              out_data.address    <= (status == ST_OK) ? address : 32'd0;
              out_data.used_bytes <= used[16:0];
              out_valid           <= 1'b1;
              st                  <= S_IDLE;
            end
          end
          default: st <= S_CLR;
        endcase
      end
      if (cfg.valid) begin
        unique case (cfg.data.index)
          REG_HEAP_BASE:    heap_base    <= cfg.data.value;
          REG_HEAP_ORDER:   heap_order   <= cfg.data.value[4:0];
          REG_HEADER_BYTES: header_bytes <= cfg.data.value[7:0];
          default: ;
        endcase
      end
    end
  end

  assign req.ready = (st == S_IDLE);
  assign cfg.ready = 1'b1;
  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

endmodule
`default_nettype wire
